// ===== rtl/fmrc_pkg.sv =====
// Shared types, codes and sizing constants for the first-match route classifier.
// Used by fmrc_match, the top level and the checker; depends on nothing.
package fmrc_pkg;

  localparam int MAX_RULES = 16;
  localparam int DEPTH     = 2 * MAX_RULES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SCAN_MAX  = (MAX_RULES < 16) ? MAX_RULES : 16;

  localparam logic [ADDR_W-1:0] BASE_GLOBAL = ADDR_W'(MAX_RULES);
  localparam logic [4:0]        SCAN_MAX_W  = 5'(SCAN_MAX);

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_LOOKUP  = 1'b1;
  localparam logic SET_APP    = 1'b0;
  localparam logic SET_GLOBAL = 1'b1;

  localparam logic CFG_APP_COUNT    = 1'b0;
  localparam logic CFG_GLOBAL_COUNT = 1'b1;

  localparam logic [1:0] KIND_PORT  = 2'd0;
  localparam logic [1:0] KIND_CIDR  = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] ACT_PROXY  = 2'd0;
  localparam logic [1:0] ACT_DIRECT = 2'd1;
  localparam logic [1:0] ACT_REJECT = 2'd2;
  localparam logic [1:0] ACT_BAD    = 2'd3;

  typedef struct packed {
    logic [15:0] port_high;
    logic [15:0] port_low;
    logic [31:0] network;
    logic [31:0] mask;
    logic [1:0]  kind;
    logic [1:0]  action;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    logic [31:0] addr;
    logic        addr_valid;
    logic [15:0] port;
  } key_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] action;
  } match_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = 32'd0;
    end else if (plen >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - plen);
    end
    return m;
  endfunction

endpackage

// ===== rtl/fmrc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fmrc_match.sv =====
// Rule match logic: compares one stored rule against the lookup key.
// Depends on fmrc_pkg.
module fmrc_match (
  input  fmrc_pkg::rule_t  rule,
  input  fmrc_pkg::key_t   key,
  output fmrc_pkg::match_t result
);

  logic port_ok;
  logic cidr_ok;

  assign port_ok = (key.port >= rule.port_low) && (key.port <= rule.port_high);
  assign cidr_ok = key.addr_valid && ((key.addr & rule.mask) == rule.network);

  always_comb begin
    result.action = rule.action;
    unique case (rule.kind)
      fmrc_pkg::KIND_PORT:  result.hit = port_ok;
      fmrc_pkg::KIND_CIDR:  result.hit = cidr_ok;
      fmrc_pkg::KIND_FINAL: result.hit = 1'b1;
      fmrc_pkg::KIND_NONE:  result.hit = 1'b0;
      default:              result.hit = 1'b0;
    endcase
  end

endmodule

// ===== rtl/first_match_route_classifier.sv =====
// Top level of the first-match route classifier: control, rule RAM and output register.
// Depends on fmrc_pkg, fmrc_ram and fmrc_match.
//
// Both rule sets live in one RAM, one entry per rule, set s at s*MAX_RULES. A write item
// stores its rule in the accept cycle and passes its result through ST_DONE to the output
// register. A lookup reads one rule per cycle through the RAM's single read port, so an item
// scans up to N rules (N = configured count, capped at MAX_RULES and 16) and stops at the
// first rule that matches. One item is in work at a time; a result may wait in the output
// register while the next item is accepted. Configuration is always ready.
module first_match_route_classifier (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic        in_rule_set,
  input  logic [3:0]  in_rule_index,
  input  logic [1:0]  in_rule_kind,
  input  logic [1:0]  in_rule_action,
  input  logic [15:0] in_port_low,
  input  logic [15:0] in_port_high,
  input  logic [31:0] in_network,
  input  logic [5:0]  in_prefix_len,
  input  logic [31:0] in_dst_addr,
  input  logic        in_addr_valid,
  input  logic [15:0] in_conn_port,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_route_action,
  output logic        out_rule_hit,
  output logic [3:0]  out_hit_index,
  output logic        out_write_done,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [4:0] app_count_r, app_count_nxt;
  logic [4:0] global_count_r, global_count_nxt;

  logic            key_set_r, key_set_nxt;
  fmrc_pkg::key_t  key_r, key_nxt;
  logic [3:0]      rd_idx_r, rd_idx_nxt;
  logic [3:0]      last_idx_r, last_idx_nxt;

  logic [1:0] res_action_r, res_action_nxt;
  logic       res_hit_r, res_hit_nxt;
  logic [3:0] res_index_r, res_index_nxt;
  logic       res_done_r, res_done_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_action_r, out_action_nxt;
  logic       out_hit_r, out_hit_nxt;
  logic [3:0] out_index_r, out_index_nxt;
  logic       out_done_r, out_done_nxt;

  logic                         accept;
  logic                         idx_ok;
  logic [4:0]                   sel_count;
  logic [4:0]                   scan_len;
  logic [fmrc_pkg::ADDR_W-1:0]  in_base;
  logic [fmrc_pkg::ADDR_W-1:0]  key_base;
  logic [fmrc_pkg::ADDR_W-1:0]  waddr;
  logic [fmrc_pkg::ADDR_W-1:0]  raddr;
  logic                         we;
  logic [31:0]                  wmask;
  logic [1:0]                   wact;
  fmrc_pkg::rule_t              wrule;
  fmrc_pkg::rule_t              rrule;
  fmrc_pkg::match_t             mres;
  logic                         out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign idx_ok    = 32'(in_rule_index) < fmrc_pkg::MAX_RULES;
  assign sel_count = (in_rule_set == fmrc_pkg::SET_GLOBAL) ? global_count_r : app_count_r;
  assign scan_len  = (sel_count > fmrc_pkg::SCAN_MAX_W) ? fmrc_pkg::SCAN_MAX_W : sel_count;

  assign in_base  = (in_rule_set == fmrc_pkg::SET_GLOBAL) ? fmrc_pkg::BASE_GLOBAL : '0;
  assign key_base = (key_set_r == fmrc_pkg::SET_GLOBAL) ? fmrc_pkg::BASE_GLOBAL : '0;
  assign waddr    = in_base + fmrc_pkg::ADDR_W'(in_rule_index);
  assign raddr    = (state_r == ST_IDLE) ? in_base
                  : key_base + fmrc_pkg::ADDR_W'({1'b0, rd_idx_r} + 5'd1);

  assign we    = accept && (in_operation == fmrc_pkg::OP_WRITE) && idx_ok;
  assign wmask = fmrc_pkg::prefix_mask(in_prefix_len);
  assign wact  = (in_rule_action == fmrc_pkg::ACT_BAD) ? fmrc_pkg::ACT_REJECT : in_rule_action;

  always_comb begin
    wrule.port_high = in_port_high;
    wrule.port_low  = in_port_low;
    wrule.network   = in_network & wmask;
    wrule.mask      = wmask;
    wrule.kind      = in_rule_kind;
    wrule.action    = wact;
  end

  fmrc_ram #(
    .WIDTH (fmrc_pkg::RULE_W),
    .DEPTH (fmrc_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrule),
    .raddr (raddr),
    .rdata (rrule)
  );

  fmrc_match u_match (
    .rule   (rrule),
    .key    (key_r),
    .result (mres)
  );

  always_comb begin
    app_count_nxt    = app_count_r;
    global_count_nxt = global_count_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmrc_pkg::CFG_APP_COUNT:    app_count_nxt    = cfg_data;
        fmrc_pkg::CFG_GLOBAL_COUNT: global_count_nxt = cfg_data;
        default:                    app_count_nxt    = app_count_r;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    key_set_nxt    = key_set_r;
    key_nxt        = key_r;
    rd_idx_nxt     = rd_idx_r;
    last_idx_nxt   = last_idx_r;
    res_action_nxt = res_action_r;
    res_hit_nxt    = res_hit_r;
    res_index_nxt  = res_index_r;
    res_done_nxt   = res_done_r;
    out_valid_nxt  = out_valid_r;
    out_action_nxt = out_action_r;
    out_hit_nxt    = out_hit_r;
    out_index_nxt  = out_index_r;
    out_done_nxt   = out_done_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_set_nxt     = in_rule_set;
          key_nxt.addr       = in_dst_addr;
          key_nxt.addr_valid = in_addr_valid;
          key_nxt.port       = in_conn_port;
          rd_idx_nxt      = 4'd0;
          last_idx_nxt    = 4'(scan_len - 5'd1);
          res_action_nxt  = fmrc_pkg::ACT_PROXY;
          res_hit_nxt     = 1'b0;
          res_index_nxt   = 4'd0;
          res_done_nxt    = 1'b0;
          if (in_operation == fmrc_pkg::OP_WRITE) begin
            res_done_nxt = idx_ok;
            state_nxt    = ST_DONE;
          end else if (scan_len == 5'd0) begin
            res_action_nxt = fmrc_pkg::ACT_DIRECT;
            state_nxt      = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (mres.hit) begin
          res_action_nxt = mres.action;
          res_hit_nxt    = 1'b1;
          res_index_nxt  = rd_idx_r;
          state_nxt      = ST_DONE;
        end else if (rd_idx_r == last_idx_r) begin
          res_action_nxt = fmrc_pkg::ACT_DIRECT;
          state_nxt      = ST_DONE;
        end else begin
          rd_idx_nxt = rd_idx_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = res_action_r;
          out_hit_nxt    = res_hit_r;
          out_index_nxt  = res_index_r;
          out_done_nxt   = res_done_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      app_count_r    <= 5'd0;
      global_count_r <= 5'd0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      app_count_r    <= app_count_nxt;
      global_count_r <= global_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_set_r    <= key_set_nxt;
    key_r        <= key_nxt;
    rd_idx_r     <= rd_idx_nxt;
    last_idx_r   <= last_idx_nxt;
    res_action_r <= res_action_nxt;
    res_hit_r    <= res_hit_nxt;
    res_index_r  <= res_index_nxt;
    res_done_r   <= res_done_nxt;
    out_action_r <= out_action_nxt;
    out_hit_r    <= out_hit_nxt;
    out_index_r  <= out_index_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_route_action = out_action_r;
  assign out_rule_hit     = out_hit_r;
  assign out_hit_index    = out_index_r;
  assign out_write_done   = out_done_r;

endmodule

// ===== rtl/fmrc_checker.sv =====
// Port-level checks for the first-match route classifier, bound to the top level.
// Depends on fmrc_pkg and first_match_route_classifier.
module fmrc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_route_action,
  input logic       out_rule_hit,
  input logic [3:0] out_hit_index,
  input logic       out_write_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_route_action)
      && $stable(out_rule_hit) && $stable(out_hit_index) && $stable(out_write_done))
    else $error("result item changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_done |-> !out_rule_hit && out_hit_index == 4'd0
      && out_route_action == fmrc_pkg::ACT_PROXY)
    else $error("write acknowledge carries lookup fields");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rule_hit |-> out_hit_index == 4'd0)
    else $error("miss reports nonzero index");

  a_hit_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rule_hit |-> !out_write_done && out_route_action != fmrc_pkg::ACT_BAD)
    else $error("hit reports bad action or write acknowledge");

endmodule

bind first_match_route_classifier fmrc_checker u_fmrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_route_action (out_route_action),
  .out_rule_hit     (out_rule_hit),
  .out_hit_index    (out_hit_index),
  .out_write_done   (out_write_done)
);
